/* hw/rtl/best_rational_approximation_top_macros.svh */
// Assertion macros shared by the rational approximation RTL.
// Depends on nothing; the checks vanish when SYNTHESIS is defined.
`ifndef BEST_RATIONAL_APPROXIMATION_TOP_MACROS_SVH
`define BEST_RATIONAL_APPROXIMATION_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define BRA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define BRA_ASSERT_SAME(label, clk, rst, ante, cons)
`define BRA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/bra_pkg.sv */
// Types and constants for the rational approximation block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package bra_pkg;

   localparam int VALUE_W           = 64;
   localparam int NUM_W             = 48;
   localparam int DENOUT_W          = 16;
   localparam int CSR_W             = 16;
   // Bound denominators stay below the 16-bit limit, so their sum needs 17 bits.
   localparam int D_W               = CSR_W + 1;
   localparam int DEN_WIDTH_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT = 32;
   localparam logic [CSR_W-1:0] LIMIT_RESET = {CSR_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MUL_LOW,
      ST_MUL_HIGH,
      ST_PICK,
      ST_SCALE,
      ST_DONE
   } bra_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_STEP,
      OP_MUL_LOW,
      OP_MUL_HIGH,
      OP_PICK,
      OP_SCALE
   } bra_op_type;

   typedef struct packed {
      bra_op_type op;
      logic       emit;
   } bra_cmd_type;

   typedef struct packed {
      logic more;
      logic out_free;
   } bra_status_type;

endpackage

/* hw/rtl/bra_req_if.sv */
// Request channel: one fixed-point value with a valid/ready handshake.
// Depends on bra_pkg for the field width.
interface bra_req_if import bra_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value_fixed;

   modport source (output valid, output value_fixed, input ready);
   modport sink (input valid, input value_fixed, output ready);
endinterface

/* hw/rtl/bra_rsp_if.sv */
// Response channel: one fraction with a valid/ready handshake.
// Depends on bra_pkg for the field widths.
interface bra_rsp_if import bra_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [NUM_W-1:0] numerator;
   logic [DENOUT_W-1:0]     denominator;

   modport source (output valid, output numerator, output denominator, input ready);
   modport sink (input valid, input numerator, input denominator, output ready);
endinterface

/* hw/rtl/bra_ctrl.sv */
// Sequencing state machine for the rational approximation block.
// Depends on bra_pkg; drives the datapath by command and reads its status.
module bra_ctrl import bra_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  bra_status_type status,
   output bra_cmd_type    cmd
);

   bra_state_type state_ff;
   bra_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.emit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.more) begin
               cmd.op = OP_STEP;
            end else begin
               state_in = ST_MUL_LOW;
            end
         end
         ST_MUL_LOW: begin
            cmd.op   = OP_MUL_LOW;
            state_in = ST_MUL_HIGH;
         end
         ST_MUL_HIGH: begin
            cmd.op   = OP_MUL_HIGH;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.op   = OP_PICK;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Wait here only while an earlier response still sits unread.
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/bra_datapath.sv */
// Datapath of the rational approximation block: limit register, mediant search
// with running error terms, final cross-multiplied compare and output register.
// Depends on bra_pkg, bra_rsp_if and the assertion macro header.
`include "best_rational_approximation_top_macros.svh"

module bra_datapath import bra_pkg::*; #(
   parameter int DEN_WIDTH = DEN_WIDTH_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_W-1:0]          csr_wdata,
   input  logic signed [VALUE_W-1:0] req_value,
   input  bra_cmd_type               cmd,
   output bra_status_type            status,
   bra_rsp_if.source                 rsp_ch
);

   localparam int LIM_BITS = (DEN_WIDTH < CSR_W) ? DEN_WIDTH : CSR_W;
   localparam logic [CSR_W-1:0] LIM_MASK = CSR_W'((64'd1 << LIM_BITS) - 64'd1);
   localparam int E_W = FRAC_BITS + 2;
   localparam int M_W = FRAC_BITS + 1;
   localparam int P_W = M_W + D_W;

   logic [CSR_W-1:0]          limit_ff;
   logic [CSR_W-1:0]          limit_masked;

   // Error terms e = f*d - n*2^FRAC_BITS of the two bounds; the mediant's
   // error is their sum, so the search needs no multiplier.
   logic signed [E_W-1:0]     e1_ff, e2_ff;
   logic [D_W-1:0]            n1_ff, d1_ff, n2_ff, d2_ff;
   logic [NUM_W-1:0]          whole_ff;
   logic [P_W-1:0]            p_low_ff, p_high_ff;
   logic [D_W-1:0]            nsel_ff, dsel_ff;
   logic [NUM_W-1:0]          res_num_ff;
   logic                      rsp_valid_ff;
   logic [NUM_W-1:0]          rsp_num_ff;
   logic [DENOUT_W-1:0]       rsp_den_ff;

   logic signed [VALUE_W-1:0] shifted;
   logic signed [E_W-1:0]     f_ext;
   logic signed [E_W-1:0]     em;
   logic signed [E_W-1:0]     neg_e2;
   logic [D_W-1:0]            nm, dm;
   logic [D_W:0]              dsum;
   logic                      em_pos;
   logic [M_W-1:0]            mul_a;
   logic [D_W-1:0]            mul_b;
   logic [P_W-1:0]            mul_p;
   logic [NUM_W+DENOUT_W-1:0] scale_p;

   assign limit_masked = csr_wdata & LIM_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         // A limit of zero is held at one.
         limit_ff <= (limit_masked == '0) ? CSR_W'(1) : limit_masked;
      end
   end

   assign shifted = req_value >>> FRAC_BITS;
   assign f_ext   = $signed({2'b00, req_value[FRAC_BITS-1:0]});
   assign em      = e1_ff + e2_ff;
   assign em_pos  = !em[E_W-1] && (em != '0);
   assign nm      = n1_ff + n2_ff;
   assign dm      = d1_ff + d2_ff;
   assign dsum    = {1'b0, d1_ff} + {1'b0, d2_ff};
   assign neg_e2  = -e2_ff;

   assign mul_a   = (cmd.op == OP_MUL_LOW) ? e1_ff[M_W-1:0] : neg_e2[M_W-1:0];
   assign mul_b   = (cmd.op == OP_MUL_LOW) ? d2_ff : d1_ff;
   assign mul_p   = mul_a * mul_b;
   assign scale_p = dsel_ff[DENOUT_W-1:0] * whole_ff;

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            e1_ff    <= f_ext;
            e2_ff    <= f_ext - $signed({2'b01, {FRAC_BITS{1'b0}}});
            n1_ff    <= '0;
            d1_ff    <= D_W'(1);
            n2_ff    <= D_W'(1);
            d2_ff    <= D_W'(1);
            whole_ff <= shifted[NUM_W-1:0];
         end
         OP_STEP: begin
            // The lower bound moves only when the value lies strictly above the mediant.
            if (em_pos) begin
               e1_ff <= em;
               n1_ff <= nm;
               d1_ff <= dm;
            end else begin
               e2_ff <= em;
               n2_ff <= nm;
               d2_ff <= dm;
            end
         end
         OP_MUL_LOW: begin
            p_low_ff <= mul_p;
         end
         OP_MUL_HIGH: begin
            p_high_ff <= mul_p;
         end
         OP_PICK: begin
            // The lower bound wins only when strictly nearer; a tie goes up.
            if (p_low_ff < p_high_ff) begin
               nsel_ff <= n1_ff;
               dsel_ff <= d1_ff;
            end else begin
               nsel_ff <= n2_ff;
               dsel_ff <= d2_ff;
            end
         end
         OP_SCALE: begin
            res_num_ff <= scale_p[NUM_W-1:0] + NUM_W'(nsel_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_num_ff <= res_num_ff;
         rsp_den_ff <= dsel_ff[DENOUT_W-1:0];
      end
   end

   assign status.more     = dsum < (D_W + 1)'(limit_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.numerator   = $signed(rsp_num_ff);
   assign rsp_ch.denominator = rsp_den_ff;

   `BRA_ASSERT_NEXT(a_load_bounds, clock, reset, cmd.op == OP_LOAD, (d1_ff == D_W'(1)) && (d2_ff == D_W'(1)) && !e1_ff[E_W-1])
   `BRA_ASSERT_SAME(a_step_signs, clock, reset, cmd.op == OP_STEP, !e1_ff[E_W-1] && (e2_ff[E_W-1] || (e2_ff == '0)))
   `BRA_ASSERT_SAME(a_step_below_limit, clock, reset, cmd.op == OP_STEP, dsum < (D_W + 1)'(limit_ff))
   `BRA_ASSERT_SAME(a_emit_slot_free, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ch.ready)

endmodule

/* hw/rtl/best_rational_approximation_top.sv */
// Channel    Direction  Handshake       Payload
// req_ch     in         valid / ready   value_fixed (signed Q32.32)
// rsp_ch     out        valid / ready   numerator (signed 48), denominator (16)
// csr        in         csr_we          csr_wdata: max_denominator
//
// A request runs k mediant steps, where k is at most max_denominator - 2, then the
// low and high cross-multiplies, the compare and the scaling; the step loop runs one
// mediant per cycle in the datapath. Requests are taken one at a time.
// Reset is synchronous and active high and loads max_denominator with 65535.
// A stalled response holds in the output register while the next request is taken;
// it stalls the following one only when that one finishes first.
// Top level: joins the controller and the datapath. Depends on bra_pkg and the
// channel interfaces.
module best_rational_approximation_top import bra_pkg::*; #(
   parameter int DEN_WIDTH = DEN_WIDTH_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,
   bra_req_if.sink          req_ch,
   bra_rsp_if.source        rsp_ch
);

   bra_cmd_type    cmd;
   bra_status_type status;
   logic           req_ready;

   assign req_ch.ready = req_ready;

   bra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bra_datapath #(
      .DEN_WIDTH (DEN_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_value (req_ch.value_fixed),
      .cmd       (cmd),
      .status    (status),
      .rsp_ch    (rsp_ch)
   );

endmodule
